// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is low
`define PPW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ppw assertion failed");

// clocked check, also checked during reset
`define PPW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ppw assertion failed");

`endif

// ===== hdl/ppw_pkg.sv =====
// shared types and constants of the projective point warp
// no dependencies
package ppw_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int PERSP_FRAC_BITS = 30;
  localparam int NUM_REGS        = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_W           = 64;
  localparam int SUM_W           = 66;  // signed numerator and denominator sums
  localparam int MAG_W           = 66;  // magnitudes
  localparam int REM_W           = 67;  // shifted partial remainder
  localparam int QUO_W           = 33;  // quotient bits kept below the overflow check
  localparam int LOW_SHIFT       = QUO_W - PERSP_FRAC_BITS;  // numerator bits that go low

  localparam logic [CFG_IDX_W-1:0] REG_LIN_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIN_D    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERSP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_BD = 3'd7;

  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] ox;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] oy;
    logic [31:0] g;
    logic [31:0] h;
    logic [31:0] i;
    logic [15:0] wmax;
    logic [15:0] hmax;
  } mat_t;

  // one coordinate lane of the divider
  typedef struct packed {
    logic             nneg;   // numerator negative
    logic             neg;    // quotient negative
    logic             nzero;  // numerator zero
    logic             ovf;    // quotient at least 2^QUO_W
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] nlo;    // numerator bits still to shift in
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic             vld;
    logic             dzero;
    logic [MAG_W-1:0] den;
    lane_t            lx;
    lane_t            ly;
  } div_t;

  typedef struct packed {
    logic        degenerate;
    logic        inside_res;
    logic [31:0] map_y;
    logic [31:0] map_x;
  } res_t;

endpackage

// ===== hdl/ppw_front.sv =====
// products, sums and magnitudes ahead of the divider chain
// depends on ppw_pkg
module ppw_front import ppw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  mat_t        mat_i,
  output div_t        div_o
);

  logic              va_q, vb_q;
  logic signed [63:0] pa_q, pb_q, pc_q, pd_q, pg_q, ph_q;
  logic signed [SUM_W-1:0] nx_q, ny_q, dn_q;
  logic signed [SUM_W-1:0] nx_d, ny_d, dn_d;
  logic [MAG_W-1:0] mx, my, md;
  div_t             div_d, div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      div_q <= '0;
    end else if (en_i) begin
      va_q  <= vld_i;
      vb_q  <= va_q;
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= $signed(mat_i.a) * $signed(point_x_i);
      pb_q <= $signed(mat_i.b) * $signed(point_y_i);
      pc_q <= $signed(mat_i.c) * $signed(point_x_i);
      pd_q <= $signed(mat_i.d) * $signed(point_y_i);
      pg_q <= $signed(mat_i.g) * $signed(point_x_i);
      ph_q <= $signed(mat_i.h) * $signed(point_y_i);
      nx_q <= nx_d;
      ny_q <= ny_d;
      dn_q <= dn_d;
    end
  end

  // the user must keep offsets and the constant term stable while items are in flight; the block does not enforce this
  always_comb begin
    nx_d = SUM_W'(pa_q) + SUM_W'(pb_q) + (SUM_W'($signed(mat_i.ox)) <<< COORD_FRAC_BITS);
    ny_d = SUM_W'(pc_q) + SUM_W'(pd_q) + (SUM_W'($signed(mat_i.oy)) <<< COORD_FRAC_BITS);
    dn_d = SUM_W'(pg_q) + SUM_W'(ph_q) + (SUM_W'($signed(mat_i.i)) <<< PERSP_FRAC_BITS);
  end

  always_comb begin
    mx = nx_q[SUM_W-1] ? MAG_W'(-nx_q) : MAG_W'(nx_q);
    my = ny_q[SUM_W-1] ? MAG_W'(-ny_q) : MAG_W'(ny_q);
    md = dn_q[SUM_W-1] ? MAG_W'(-dn_q) : MAG_W'(dn_q);
    div_d          = '0;
    div_d.vld      = vb_q;
    div_d.dzero    = (dn_q == '0);
    div_d.den      = md;
    div_d.lx.nneg  = nx_q[SUM_W-1];
    div_d.lx.neg   = nx_q[SUM_W-1] ^ dn_q[SUM_W-1];
    div_d.lx.nzero = (nx_q == '0);
    div_d.lx.ovf   = (mx >> LOW_SHIFT) >= md;
    div_d.lx.rem   = REM_W'(mx >> LOW_SHIFT);
    div_d.lx.nlo   = {mx[LOW_SHIFT-1:0], {PERSP_FRAC_BITS{1'b0}}};
    div_d.ly.nneg  = ny_q[SUM_W-1];
    div_d.ly.neg   = ny_q[SUM_W-1] ^ dn_q[SUM_W-1];
    div_d.ly.nzero = (ny_q == '0);
    div_d.ly.ovf   = (my >> LOW_SHIFT) >= md;
    div_d.ly.rem   = REM_W'(my >> LOW_SHIFT);
    div_d.ly.nlo   = {my[LOW_SHIFT-1:0], {PERSP_FRAC_BITS{1'b0}}};
  end

  assign div_o = div_q;

endmodule

// ===== hdl/ppw_div_cell.sv =====
// one restoring-division cell: one quotient bit for each lane per cell
// depends on ppw_pkg
module ppw_div_cell import ppw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t div_d, div_q;

  function automatic lane_t step(lane_t l, logic [MAG_W-1:0] den);
    logic [REM_W-1:0] sh;
    logic [REM_W:0]   diff;
    lane_t            r;
    r    = l;
    sh   = {l.rem[REM_W-2:0], l.nlo[QUO_W-1]};
    diff = {1'b0, sh} - (REM_W+1)'(den);
    r.nlo = {l.nlo[QUO_W-2:0], 1'b0};
    if (!diff[REM_W]) begin
      r.rem = diff[REM_W-1:0];
      r.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = sh;
      r.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    div_d    = div_i;
    div_d.lx = step(div_i.lx, div_i.den);
    div_d.ly = step(div_i.ly, div_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// ===== hdl/ppw_out.sv =====
// result forming, saturation, bounds test and output register with skid
// depends on ppw_pkg
module ppw_out import ppw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_t        div_i,
  input  logic        push_i,
  input  logic [15:0] wmax_i,
  input  logic [15:0] hmax_i,
  input  logic        m_tready_i,
  output logic        m_tvalid_o,
  output res_t        res_o,
  output logic        en_o
);

  res_t res_d, out_q, skid_q;
  logic out_vld_q, skid_vld_q;

  function automatic logic [31:0] coord(lane_t l, logic [31:0] bound, output logic in_rng);
    logic [31:0] v;
    if (l.nzero) begin
      v      = '0;
      in_rng = 1'b1;
    end else if (l.neg) begin
      in_rng = 1'b0;
      if (l.ovf || l.quo > QUO_W'(SAT_NEG)) v = SAT_NEG;
      else v = 32'(-l.quo);
    end else begin
      in_rng = !l.ovf && ((l.quo < QUO_W'(bound)) ||
                          (l.quo == QUO_W'(bound) && l.rem == '0));
      if (l.ovf || l.quo[QUO_W-1] || l.quo[31]) v = SAT_POS;
      else v = l.quo[31:0];
    end
    return v;
  endfunction

  always_comb begin
    logic ix, iy;
    logic [31:0] wb, hb;
    wb = 32'(wmax_i) << COORD_FRAC_BITS;
    hb = 32'(hmax_i) << COORD_FRAC_BITS;
    res_d.map_x = coord(div_i.lx, wb, ix);
    res_d.map_y = coord(div_i.ly, hb, iy);
    res_d.inside_res = ix & iy;
    res_d.degenerate = 1'b0;
    if (div_i.dzero) begin
      res_d.map_x      = div_i.lx.nneg ? SAT_NEG : SAT_POS;
      res_d.map_y      = div_i.ly.nneg ? SAT_NEG : SAT_POS;
      res_d.inside_res = 1'b0;
      res_d.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_tready_i) begin
      out_vld_q  <= skid_vld_q | push_i;
      skid_vld_q <= 1'b0;
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_tready_i) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (push_i) begin
      skid_q <= res_d;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign res_o      = out_q;
  assign en_o       = !skid_vld_q;

endmodule

// ===== hdl/projective_point_warp.sv =====
// top level of the projective point warp: config registers, front end,
// divider cell chain and output stage; depends on ppw_pkg and the ppw_* modules
//
//   channel  | direction | tdata fields (low bit up)
//   s_axis   | in        | point_x[31:0], point_y[63:32]
//   m_axis   | out       | map_x[31:0], map_y[63:32], inside_res[64],
//            |           | degenerate[65], zero pad[71:66]
//   cfg      | in        | write enable, 3-bit register index, 64-bit data
//
// one point per clock unless the skid is full; path: front-end registers, 33 divider
// cells (one quotient bit per cell for both coordinates) and one output register
// reset clears all valid flags and loads the identity matrix
// a stalled output fills a one-entry skid, then the whole chain holds
module projective_point_warp import ppw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // point_x, point_y
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [71:0]          m_axis_tdata,   // map_x, map_y, inside_res, degenerate
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic [CFG_W-1:0] reg_q [NUM_REGS];
  mat_t             mat;
  logic             en;
  div_t             chain [QUO_W+1];
  res_t             res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q[REG_LIN_A]    <= 64'd65536;
      reg_q[REG_LIN_B]    <= '0;
      reg_q[REG_OFFSET_X] <= '0;
      reg_q[REG_LIN_C]    <= '0;
      reg_q[REG_LIN_D]    <= 64'd65536;
      reg_q[REG_OFFSET_Y] <= '0;
      reg_q[REG_PERSP]    <= '0;
      reg_q[REG_CONST_BD] <= 64'h0001_0000_0000_0000;
    end else if (cfg_we_i) begin
      reg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    mat.a    = reg_q[REG_LIN_A][31:0];
    mat.b    = reg_q[REG_LIN_B][31:0];
    mat.ox   = reg_q[REG_OFFSET_X][31:0];
    mat.c    = reg_q[REG_LIN_C][31:0];
    mat.d    = reg_q[REG_LIN_D][31:0];
    mat.oy   = reg_q[REG_OFFSET_Y][31:0];
    mat.g    = reg_q[REG_PERSP][63:32];
    mat.h    = reg_q[REG_PERSP][31:0];
    mat.i    = reg_q[REG_CONST_BD][63:32];
    mat.wmax = reg_q[REG_CONST_BD][31:16];
    mat.hmax = reg_q[REG_CONST_BD][15:0];
  end

  assign s_axis_tready = en;

  ppw_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (s_axis_tvalid),
    .point_x_i (s_axis_tdata[31:0]),
    .point_y_i (s_axis_tdata[63:32]),
    .mat_i     (mat),
    .div_o     (chain[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    ppw_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .div_i  (chain[k]),
      .div_o  (chain[k+1])
    );
  end

  ppw_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .div_i      (chain[QUO_W]),
    .push_i     (chain[QUO_W].vld & en),
    .wmax_i     (mat.wmax),
    .hmax_i     (mat.hmax),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .res_o      (res),
    .en_o       (en)
  );

  assign m_axis_tdata = {6'd0, res};

endmodule

// ===== hdl/ppw_checker.sv =====
// port-level checks on the projective point warp, bound to the top level
// depends on ppw_pkg and assert_macros.svh
`include "assert_macros.svh"

module ppw_checker import ppw_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  logic        deg, ins;
  logic [31:0] res_x, res_y;

  assign deg   = m_axis_tdata[65];
  assign ins   = m_axis_tdata[64];
  assign res_x = m_axis_tdata[31:0];
  assign res_y = m_axis_tdata[63:32];

  // degenerate results never count as inside
  `PPW_ASSERT(a_deg_not_inside, clk_i, rst_ni, m_axis_tvalid && deg |-> !ins)

  // degenerate results carry saturated x
  `PPW_ASSERT(a_deg_sat, clk_i, rst_ni, m_axis_tvalid && deg |-> (res_x == SAT_POS || res_x == SAT_NEG))

  // an inside point has non-negative coordinates
  `PPW_ASSERT(a_inside_pos, clk_i, rst_ni, m_axis_tvalid && ins |-> !res_x[31] && !res_y[31])

  // stalled result holds
  `PPW_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind projective_point_warp ppw_checker u_ppw_checker (.*);

// ===== tb/projective_point_warp_tb.sv =====
// self-checking bench for projective_point_warp: drives points through the stream
// port under several matrix settings and checks each mapped point; needs ppw_pkg
`timescale 1ns / 100ps

module projective_point_warp_tb;
  import ppw_pkg::*;

  class warp_checker;
    logic [CFG_W-1:0] regs [NUM_REGS];
    res_t             pending_pts[$];
    int               n_err;

    function new();
      n_err = 0;
      regs[REG_LIN_A]    = 64'd65536;
      regs[REG_LIN_B]    = '0;
      regs[REG_OFFSET_X] = '0;
      regs[REG_LIN_C]    = '0;
      regs[REG_LIN_D]    = 64'd65536;
      regs[REG_OFFSET_Y] = '0;
      regs[REG_PERSP]    = '0;
      regs[REG_CONST_BD] = 64'h0001_0000_0000_0000;
    endfunction

    function logic signed [127:0] sx(input logic [31:0] v);
      return {{96{v[31]}}, v};
    endfunction

    // truncating divide of num * 2^30 by den, saturated; inr judged on exact quotient
    function logic [31:0] div_coord(input logic signed [127:0] num, den,
                                    input logic [47:0] bnd, output bit inr);
      logic [127:0] an, ad, q, r;
      bit           neg;
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      an  = an << PERSP_FRAC_BITS;
      q   = an / ad;
      r   = an % ad;
      if (num == 0) begin
        inr = 1;
        return '0;
      end
      if (neg) begin
        inr = 0;
        if (q > 128'h8000_0000) return SAT_NEG;
        return 32'(-q);
      end
      inr = (q < bnd) || (q == bnd && r == 0);
      if (q > 128'h7FFF_FFFF) return SAT_POS;
      return q[31:0];
    endfunction

    function void note_point(input logic [31:0] px, py);
      logic signed [127:0] x, y, nx, ny, den;
      logic [47:0]         wb, hb;
      bit                  ix, iy;
      res_t                r;
      x   = sx(px);
      y   = sx(py);
      nx  = sx(regs[REG_LIN_A][31:0]) * x + sx(regs[REG_LIN_B][31:0]) * y
            + (sx(regs[REG_OFFSET_X][31:0]) <<< COORD_FRAC_BITS);
      ny  = sx(regs[REG_LIN_C][31:0]) * x + sx(regs[REG_LIN_D][31:0]) * y
            + (sx(regs[REG_OFFSET_Y][31:0]) <<< COORD_FRAC_BITS);
      den = sx(regs[REG_PERSP][63:32]) * x + sx(regs[REG_PERSP][31:0]) * y
            + (sx(regs[REG_CONST_BD][63:32]) <<< PERSP_FRAC_BITS);
      wb  = 48'(regs[REG_CONST_BD][31:16]) << COORD_FRAC_BITS;
      hb  = 48'(regs[REG_CONST_BD][15:0]) << COORD_FRAC_BITS;
      if (den == 0) begin
        r.map_x      = (nx < 0) ? SAT_NEG : SAT_POS;
        r.map_y      = (ny < 0) ? SAT_NEG : SAT_POS;
        r.inside_res = 0;
        r.degenerate = 1;
      end else begin
        r.map_x      = div_coord(nx, den, wb, ix);
        r.map_y      = div_coord(ny, den, hb, iy);
        r.inside_res = ix && iy;
        r.degenerate = 0;
      end
      pending_pts.push_back(r);
    endfunction

    function void check_point(input logic [71:0] data);
      res_t got, exp_r;
      got = data[65:0];
      if (pending_pts.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected output transfer %h", data);
        return;
      end
      exp_r = pending_pts.pop_front();
      if (got.map_x !== exp_r.map_x || got.map_y !== exp_r.map_y ||
          got.inside_res !== exp_r.inside_res || got.degenerate !== exp_r.degenerate) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch: exp x=%h y=%h in=%b dg=%b  got x=%h y=%h in=%b dg=%b",
                   exp_r.map_x, exp_r.map_y, exp_r.inside_res, exp_r.degenerate,
                   got.map_x, got.map_y, got.inside_res, got.degenerate);
      end
    endfunction
  endclass

  logic                 clk_i = 0;
  logic                 rst_ni = 0;
  logic                 s_axis_tvalid = 0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;   // point_x, point_y
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 0;
  logic [71:0]          m_axis_tdata;        // map_x, map_y, inside_res, degenerate
  logic                 cfg_we_i = 0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  warp_checker chk = new();
  bit          calm = 0;
  int          quiet_cycles = 0;

  projective_point_warp u_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= 17);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) chk.check_point(m_axis_tdata);
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    chk.regs[idx] = val;
  endtask

  task automatic load_matrix(input logic [31:0] a, b, ox, c, d, oy, g, h, i,
                             input logic [15:0] wmax, hmax);
    write_reg(REG_LIN_A, 64'(a));
    write_reg(REG_LIN_B, 64'(b));
    write_reg(REG_OFFSET_X, 64'(ox));
    write_reg(REG_LIN_C, 64'(c));
    write_reg(REG_LIN_D, 64'(d));
    write_reg(REG_OFFSET_Y, 64'(oy));
    write_reg(REG_PERSP, {g, h});
    write_reg(REG_CONST_BD, {i, wmax, hmax});
  endtask

  // wait until every point is back, then let the pipeline go quiet
  task automatic drain();
    while (chk.pending_pts.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic send_point(input logic [31:0] px, py);
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    chk.note_point(px, py);
    @(negedge clk_i);
  endtask

  task automatic random_points(input int n);
    logic [31:0] px, py;
    logic [31:0] xr, yr;
    xr = (32'(chk.regs[REG_CONST_BD][31:16]) + 2) << COORD_FRAC_BITS;
    yr = (32'(chk.regs[REG_CONST_BD][15:0]) + 2) << COORD_FRAC_BITS;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1)) begin
        px = $urandom_range(xr) - 32'(65536);
        py = $urandom_range(yr) - 32'(65536);
      end else begin
        px = $urandom;
        py = $urandom;
      end
      send_point(px, py);
    end
    s_axis_tvalid <= 0;
  endtask

  function automatic logic [31:0] near(input int centre, input int span);
    return 32'(centre) + 32'($urandom_range(2 * span)) - 32'(span);
  endfunction

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // reset matrix: identity, bounds zero so only the origin is inside
    send_point(32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h1);
    send_point(32'h1, 32'h0);
    s_axis_tvalid <= 0;
    drain();

    // identity on a 640x480 image: edges, fractions just past them, negative points
    load_matrix(32'd65536, 0, 0, 0, 32'd65536, 0, 0, 0, 32'd65536, 16'd639, 16'd479);
    send_point(32'd639 << 16, 32'd479 << 16);
    send_point((32'd639 << 16) + 1, 32'd479 << 16);
    send_point(32'd100 << 16, (32'd479 << 16) + 1);
    send_point(32'hFFFF_FFFF, 32'd5 << 16);
    send_point(32'd5 << 16, 32'h8000_0000);
    s_axis_tvalid <= 0;
    drain();

    // zero denominator everywhere: numerator sign picks the saturation
    load_matrix(32'd65536, 0, 0, 32'hFFFF_0000, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF);
    send_point(32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0);
    send_point(32'hFFFF_0000, 32'h0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    s_axis_tvalid <= 0;
    drain();

    // perspective that flips sign of the denominator, small divisor overflow
    load_matrix(32'd65536, 0, 32'd10 << 16, 0, 32'd65536, 32'hFFF6_0000,
                32'hFFFF_C000, 32'd16384, 32'd1, 16'd1000, 16'd1000);
    send_point(32'd20 << 16, 32'd10 << 16);
    send_point(32'd0, 32'd0);
    send_point(32'h7FFF_FFFF, 32'h0);
    send_point(32'h0, 32'h8000_0000);
    s_axis_tvalid <= 0;
    drain();

    // extremes of every register
    load_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                16'hFFFF, 16'hFFFF);
    random_points(40);
    drain();
    load_matrix(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 16'd0);
    random_points(40);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      calm = (ph == 3);
      if (ph % 3 == 2)
        load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom));
      else
        load_matrix(near(65536, 40000), near(0, 30000), near(0, 200 << 16),
                    near(0, 30000), near(65536, 40000), near(0, 200 << 16),
                    (ph % 3 == 0) ? 32'h0 : near(0, 2048),
                    (ph % 3 == 0) ? 32'h0 : near(0, 2048),
                    near(65536, 16384),
                    16'($urandom_range(1, 1023)), 16'($urandom_range(1, 1023)));
      random_points(85);
      drain();
    end
    calm = 0;

    if (chk.n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== projective_point_warp.f =====
+incdir+hdl
hdl/ppw_pkg.sv
hdl/ppw_front.sv
hdl/ppw_div_cell.sv
hdl/ppw_out.sv
hdl/projective_point_warp.sv
hdl/ppw_checker.sv
tb/projective_point_warp_tb.sv
